// ----- sv/sid_pkg.sv -----
// Shared types and constants for the signed integer divider.
// Used by the channel interfaces and every divider module; depends on nothing.
package sid_pkg;

   // Default operand width in bits.
   localparam int DEFAULT_WIDTH = 32;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } sid_status_type;

   // Per-word side information that travels down the cell chain.
   typedef struct packed {
      logic neg_q;
      logic div_zero;
   } sid_flags_type;

endpackage

// ----- sv/sid_if.sv -----
// Valid/ready channel interfaces for the divider request and response words.
// Depends on sid_pkg for the default width.
interface sid_req_if #(parameter int WIDTH = sid_pkg::DEFAULT_WIDTH);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] dividend;
   logic [WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sid_rsp_if #(parameter int WIDTH = sid_pkg::DEFAULT_WIDTH);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] quotient;
   logic [1:0]       status;

   modport source (output valid, output quotient, output status, input ready);
   modport sink   (input valid, input quotient, input status, output ready);
endinterface

// ----- sv/sid_front.sv -----
// Input stage: takes a request word and registers operand magnitudes, quotient sign and divide-by-zero flags.
// Depends on sid_pkg and sid_req_if.
module sid_front #(
   parameter int WIDTH = sid_pkg::DEFAULT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   sid_req_if.sink               req,
   output logic                  dn_valid,
   output logic [WIDTH-1:0]      dn_num,
   output logic [WIDTH-1:0]      dn_den,
   output sid_pkg::sid_flags_type dn_flags
);

   logic                   valid_ff;
   logic [WIDTH-1:0]       num_ff;
   logic [WIDTH-1:0]       num_in;
   logic [WIDTH-1:0]       den_ff;
   logic [WIDTH-1:0]       den_in;
   sid_pkg::sid_flags_type flags_ff;
   sid_pkg::sid_flags_type flags_in;
   logic                   neg_a;
   logic                   neg_b;

   // The whole chain moves together, so a word is taken whenever it advances.
   assign req.ready = advance;

   // Operand magnitudes and the sign of the quotient.
   always_comb begin
      neg_a             = req.dividend[WIDTH-1];
      neg_b             = req.divisor[WIDTH-1];
      num_in            = neg_a ? (~req.dividend + WIDTH'(1)) : req.dividend;
      den_in            = neg_b ? (~req.divisor + WIDTH'(1)) : req.divisor;
      flags_in.neg_q    = neg_a ^ neg_b;
      flags_in.div_zero = (req.divisor == '0);
   end

   // Valid bit of the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req.valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         flags_ff <= flags_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_num   = num_ff;
   assign dn_den   = den_ff;
   assign dn_flags = flags_ff;

endmodule

// ----- sv/sid_cell.sv -----
// One restoring-division cell: produces one quotient bit and hands the word on.
// Depends on sid_pkg.
module sid_cell #(
   parameter int WIDTH = sid_pkg::DEFAULT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   up_valid,
   input  logic [WIDTH-1:0]       up_rem,
   input  logic [WIDTH-1:0]       up_quo,
   input  logic [WIDTH-1:0]       up_num,
   input  logic [WIDTH-1:0]       up_den,
   input  sid_pkg::sid_flags_type up_flags,
   output logic                   dn_valid,
   output logic [WIDTH-1:0]       dn_rem,
   output logic [WIDTH-1:0]       dn_quo,
   output logic [WIDTH-1:0]       dn_num,
   output logic [WIDTH-1:0]       dn_den,
   output sid_pkg::sid_flags_type dn_flags
);

   logic                   valid_ff;
   logic [WIDTH-1:0]       rem_ff;
   logic [WIDTH-1:0]       rem_in;
   logic [WIDTH-1:0]       quo_ff;
   logic [WIDTH-1:0]       quo_in;
   logic [WIDTH-1:0]       num_ff;
   logic [WIDTH-1:0]       num_in;
   logic [WIDTH-1:0]       den_ff;
   sid_pkg::sid_flags_type flags_ff;
   logic [WIDTH:0]         trial_rem;
   logic [WIDTH:0]         diff;
   logic                   fits;

   // Bring down the next dividend bit and try to subtract the divisor.
   always_comb begin
      trial_rem = {up_rem, up_num[WIDTH-1]};
      diff      = trial_rem - {1'b0, up_den};
      fits      = ~diff[WIDTH];
      rem_in    = fits ? diff[WIDTH-1:0] : trial_rem[WIDTH-1:0];
      quo_in    = {up_quo[WIDTH-2:0], fits};
      num_in    = {up_num[WIDTH-2:0], 1'b0};
   end

   // Valid bit of this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   // Partial remainder, quotient and operands handed to the next cell.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         num_ff   <= num_in;
         den_ff   <= up_den;
         flags_ff <= up_flags;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;
   assign dn_num   = num_ff;
   assign dn_den   = den_ff;
   assign dn_flags = flags_ff;

endmodule

// ----- sv/sid_back.sv -----
// Output stage: sign fix-up, overflow and divide-by-zero handling, response register.
// Depends on sid_pkg and sid_rsp_if.
module sid_back #(
   parameter int WIDTH = sid_pkg::DEFAULT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   input  logic [WIDTH-1:0]       up_quo,
   input  sid_pkg::sid_flags_type up_flags,
   output logic                   advance,
   sid_rsp_if.source              rsp
);

   localparam logic [WIDTH-1:0] MaxPos = {1'b0, {(WIDTH-1){1'b1}}};

   logic                    valid_ff;
   logic [WIDTH-1:0]        quo_ff;
   logic [WIDTH-1:0]        quo_in;
   sid_pkg::sid_status_type status_ff;
   sid_pkg::sid_status_type status_in;

   // The chain moves unless a finished word waits and the receiver stalls.
   assign advance = ~valid_ff | rsp.ready;

   // Final quotient and status.
   always_comb begin
      priority if (up_flags.div_zero) begin
         quo_in    = '0;
         status_in = sid_pkg::STATUS_DIV_ZERO;
      end else if (up_flags.neg_q) begin
         quo_in    = ~up_quo + WIDTH'(1);
         status_in = sid_pkg::STATUS_OK;
      end else if (up_quo[WIDTH-1]) begin
         // Most negative value divided by minus one does not fit.
         quo_in    = MaxPos;
         status_in = sid_pkg::STATUS_OVERFLOW;
      end else begin
         quo_in    = up_quo;
         status_in = sid_pkg::STATUS_OK;
      end
   end

   // Response valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff    <= quo_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.status   = status_ff;

endmodule

// ----- sv/signed_int_divider.sv -----
// Top level of the signed integer divider: input stage, chain of division cells,
// output stage. Depends on sid_pkg, sid_if, sid_front, sid_cell and sid_back.
//
// Usage:
//   req_chan carries a word of dividend and divisor (two's complement, WIDTH
//   bits each); rsp_chan returns the quotient truncated toward zero and a
//   status: 0 normal, 1 overflow (most negative over minus one, quotient
//   saturated to the largest positive value), 2 divide by zero (quotient 0).
//   A word moves on either channel when valid and ready are both high.
// Pipeline and throughput:
//   A word taken from req_chan passes through the input stage register, which
//   holds the operand magnitudes, then through the WIDTH cells of the chain
//   (one quotient bit per cell), and then into the output register that
//   drives rsp_chan. The sign fix-up is done on the way into the output
//   register. One word can be taken every cycle while the chain does not
//   stall.
// Stalls:
//   While the response register holds a word that the receiver does not take,
//   the whole chain holds and req_chan.ready is low.
// Reset:
//   Reset clears every valid bit; words in flight are dropped.
module signed_int_divider #(
   parameter int WIDTH = sid_pkg::DEFAULT_WIDTH
) (
   input logic       clock,
   input logic       reset,
   sid_req_if.sink   req_chan,
   sid_rsp_if.source rsp_chan
);

   logic                   advance;
   logic                   valid_w [WIDTH+1];
   logic [WIDTH-1:0]       rem_w   [WIDTH+1];
   logic [WIDTH-1:0]       quo_w   [WIDTH+1];
   logic [WIDTH-1:0]       num_w   [WIDTH+1];
   logic [WIDTH-1:0]       den_w   [WIDTH+1];
   sid_pkg::sid_flags_type flags_w [WIDTH+1];

   // Input stage.
   sid_front #(.WIDTH(WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req      (req_chan),
      .dn_valid (valid_w[0]),
      .dn_num   (num_w[0]),
      .dn_den   (den_w[0]),
      .dn_flags (flags_w[0])
   );

   // The chain starts from an empty remainder and quotient.
   assign rem_w[0] = '0;
   assign quo_w[0] = '0;

   // One cell per quotient bit, most significant bit first.
   for (genvar k = 0; k < WIDTH; k++) begin : g_cell
      sid_cell #(.WIDTH(WIDTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_valid (valid_w[k]),
         .up_rem   (rem_w[k]),
         .up_quo   (quo_w[k]),
         .up_num   (num_w[k]),
         .up_den   (den_w[k]),
         .up_flags (flags_w[k]),
         .dn_valid (valid_w[k+1]),
         .dn_rem   (rem_w[k+1]),
         .dn_quo   (quo_w[k+1]),
         .dn_num   (num_w[k+1]),
         .dn_den   (den_w[k+1]),
         .dn_flags (flags_w[k+1])
      );
   end

   // Output stage.
   sid_back #(.WIDTH(WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid_w[WIDTH]),
      .up_quo   (quo_w[WIDTH]),
      .up_flags (flags_w[WIDTH]),
      .advance  (advance),
      .rsp      (rsp_chan)
   );

`ifndef ASSERT_OFF
   // A stalled chain keeps the word at its end in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_w[WIDTH]) && $stable(quo_w[WIDTH]))
      else $error("cell chain moved during a stall");

   // A divide by zero always answers with a zero quotient.
   a_div_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == sid_pkg::STATUS_DIV_ZERO)
      |-> (rsp_chan.quotient == '0))
      else $error("divide by zero with nonzero quotient");

   // Overflow saturates to the largest positive value.
   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == sid_pkg::STATUS_OVERFLOW)
      |-> (rsp_chan.quotient == {1'b0, {(WIDTH-1){1'b1}}}))
      else $error("overflow quotient not saturated");
`endif

endmodule
